[rtl/core/tsp_pkg.sv]
// Shared types and constants for the greedy + 2-opt tour search block.
// No dependencies.
package tsp_pkg;

  localparam int unsigned ROWCOL_W   = 5;
  localparam int unsigned DIN_W      = 16;
  localparam int unsigned CFG_W      = 6;
  localparam int unsigned POS_OUT_W  = 6;
  localparam int unsigned CITY_OUT_W = 5;
  localparam int unsigned COST_W     = 22;
  localparam int unsigned S_TDATA_W  = 32;
  localparam int unsigned M_TDATA_W  = 56;

  localparam logic [CFG_W-1:0]  CITY_COUNT_RST = 6'd32;
  localparam logic [COST_W-1:0] COST_MAX       = 22'h3FFFFF;

  // One result beat pushed from the engine toward the output register.
  typedef struct packed {
    logic                  valid;
    logic [POS_OUT_W-1:0]  position;
    logic [CITY_OUT_W-1:0] city;
    logic [COST_W-1:0]     greedy_cost;
    logic [COST_W-1:0]     tour_cost;
    logic                  last;
  } tsp_beat_t;

endpackage

[rtl/core/tsp_greedy_two_opt_tour.sv]
// Top level of the greedy nearest-neighbor + 2-opt tour search block.
// Depends on tsp_pkg, tsp_ram and tsp_engine.
//
// Matrix entries load at one beat per cycle into the distance RAM. A beat
// with tlast starts the search and the slave side stalls until the last
// tour position has been handed to the output register. With n cities the
// greedy build scans the current city's row through the single distance RAM
// read port for each step. Each 2-opt move test walks the segment from i+1
// to j, a reversal swaps one pair of entries at a time, and a sweep repeats
// until no move gains; the number of sweeps depends on the data. Readout gives n+1 positions.
module tsp_greedy_two_opt_tour #(
  parameter int unsigned MAX_CITIES = 32,
  parameter int unsigned DIST_BITS  = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tsp_pkg::CFG_W-1:0]        cfg_wdata_i,    // city_count
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [tsp_pkg::S_TDATA_W-1:0]    s_axis_tdata,   // row[4:0] col[9:5] distance[25:10]
  input  logic                             s_axis_tlast,   // final_entry
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [tsp_pkg::M_TDATA_W-1:0]    m_axis_tdata,   // position[5:0] city[10:6]
                                                           // greedy_cost[32:11] tour_cost[54:33]
  output logic                             m_axis_tlast    // last
);
  import tsp_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_CITIES + 1);
  localparam int unsigned CITY_W = $clog2(MAX_CITIES);
  localparam int unsigned ADDR_W = $clog2(MAX_CITIES * MAX_CITIES);

  logic [CFG_W-1:0]     city_count_q;
  logic [CNT_W-1:0]     n_eff;
  logic [ROWCOL_W-1:0]  row, col;
  logic                 in_acc, d_we, start, busy;
  logic [ADDR_W-1:0]    d_waddr, d_raddr;
  logic                 d_re;
  logic [DIST_BITS-1:0] d_rdata;
  logic                 t_we, t_re;
  logic [CNT_W-1:0]     t_waddr, t_raddr;
  logic [CITY_W-1:0]    t_wdata, t_rdata;
  logic                 out_free;
  tsp_beat_t            beat;
  logic                 ovalid_q;
  logic [M_TDATA_W-1:0] odata_q;
  logic                 olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      city_count_q <= CITY_COUNT_RST;
    end else if (cfg_we_i) begin
      city_count_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (city_count_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (7'(city_count_q) > 7'(MAX_CITIES)) begin
      n_eff = CNT_W'(MAX_CITIES);
    end else begin
      n_eff = CNT_W'(city_count_q);
    end
  end

  assign row           = s_axis_tdata[4:0];
  assign col           = s_axis_tdata[9:5];
  assign s_axis_tready = ~busy;
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign d_we          = in_acc && (7'(row) < 7'(MAX_CITIES)) && (7'(col) < 7'(MAX_CITIES));
  assign d_waddr       = ADDR_W'(row) * ADDR_W'(MAX_CITIES) + ADDR_W'(col);
  assign start         = in_acc & s_axis_tlast;

  tsp_ram #(
    .WIDTH (DIST_BITS),
    .DEPTH (MAX_CITIES * MAX_CITIES)
  ) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_waddr),
    .wdata_i (DIST_BITS'(s_axis_tdata[25:10])),
    .re_i    (d_re),
    .raddr_i (d_raddr),
    .rdata_o (d_rdata)
  );

  tsp_ram #(
    .WIDTH (CITY_W),
    .DEPTH (MAX_CITIES + 1)
  ) u_tour_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .re_i    (t_re),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  tsp_engine #(
    .MAX_CITIES (MAX_CITIES),
    .DIST_BITS  (DIST_BITS)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .n_i        (n_eff),
    .busy_o     (busy),
    .dre_o      (d_re),
    .draddr_o   (d_raddr),
    .drdata_i   (d_rdata),
    .twe_o      (t_we),
    .twaddr_o   (t_waddr),
    .twdata_o   (t_wdata),
    .tre_o      (t_re),
    .traddr_o   (t_raddr),
    .trdata_i   (t_rdata),
    .out_free_i (out_free),
    .beat_o     (beat)
  );

  assign out_free = ~ovalid_q | m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (beat.valid) begin
      ovalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat.valid) begin
      odata_q <= {1'b0, beat.tour_cost, beat.greedy_cost, beat.city, beat.position};
      olast_q <= beat.last;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tlast  = olast_q;

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat.valid |-> out_free)
    else $error("result beat pushed into a full output register");

  a_tour_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (t_we && t_re) |-> (t_waddr != t_raddr))
    else $error("tour RAM read and write hit the same entry");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> busy)
    else $error("search did not start after final entry");

  a_no_dist_read_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> !(d_re || t_re || t_we))
    else $error("memory access while engine idle");

endmodule

[rtl/core/tsp_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tsp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/tsp_engine.sv]
// Tour search sequencer: greedy build, 2-opt sweeps and result readout.
// Depends on tsp_pkg; drives the distance and tour RAM ports of the top level.
module tsp_engine #(
  parameter int unsigned MAX_CITIES = 32,
  parameter int unsigned DIST_BITS  = 16
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        start_i,
  input  logic [$clog2(MAX_CITIES+1)-1:0]             n_i,
  output logic                                        busy_o,
  output logic                                        dre_o,
  output logic [$clog2(MAX_CITIES*MAX_CITIES)-1:0]    draddr_o,
  input  logic [DIST_BITS-1:0]                        drdata_i,
  output logic                                        twe_o,
  output logic [$clog2(MAX_CITIES+1)-1:0]             twaddr_o,
  output logic [$clog2(MAX_CITIES)-1:0]               twdata_o,
  output logic                                        tre_o,
  output logic [$clog2(MAX_CITIES+1)-1:0]             traddr_o,
  input  logic [$clog2(MAX_CITIES)-1:0]               trdata_i,
  input  logic                                        out_free_i,
  output tsp_pkg::tsp_beat_t                          beat_o
);
  import tsp_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_CITIES + 1);
  localparam int unsigned PW     = CNT_W + 1;
  localparam int unsigned CITY_W = $clog2(MAX_CITIES);
  localparam int unsigned ADDR_W = $clog2(MAX_CITIES * MAX_CITIES);
  localparam int unsigned LEN_W  = DIST_BITS + CNT_W;
  localparam int unsigned DW     = LEN_W + 2;
  localparam int unsigned SW     = (LEN_W > COST_W) ? LEN_W : COST_W;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_GINIT = 5'd1;
  localparam logic [4:0] S_GS0   = 5'd2;
  localparam logic [4:0] S_GS1   = 5'd3;
  localparam logic [4:0] S_GPICK = 5'd4;
  localparam logic [4:0] S_GCLS  = 5'd5;
  localparam logic [4:0] S_GSUM  = 5'd6;
  localparam logic [4:0] S_TA    = 5'd7;
  localparam logic [4:0] S_TB    = 5'd8;
  localparam logic [4:0] S_TC    = 5'd9;
  localparam logic [4:0] S_TD    = 5'd10;
  localparam logic [4:0] S_TE    = 5'd11;
  localparam logic [4:0] S_D1    = 5'd12;
  localparam logic [4:0] S_D2    = 5'd13;
  localparam logic [4:0] S_D3    = 5'd14;
  localparam logic [4:0] S_D4    = 5'd15;
  localparam logic [4:0] S_K1    = 5'd16;
  localparam logic [4:0] S_K2    = 5'd17;
  localparam logic [4:0] S_K3    = 5'd18;
  localparam logic [4:0] S_DEC   = 5'd19;
  localparam logic [4:0] S_R1    = 5'd20;
  localparam logic [4:0] S_R2    = 5'd21;
  localparam logic [4:0] S_R3    = 5'd22;
  localparam logic [4:0] S_R4    = 5'd23;
  localparam logic [4:0] S_NXT   = 5'd24;
  localparam logic [4:0] S_ORD   = 5'd25;
  localparam logic [4:0] S_OWT   = 5'd26;

  logic [4:0]            state_q, state_d;
  logic [PW-1:0]         n_q, n_d;
  logic [PW-1:0]         i_q, i_d, j_q, j_d, k_q, k_d;
  logic [CNT_W-1:0]      sc_q, sc_d;
  logic [CITY_W-1:0]     cur_q, cur_d, pick_q, pick_d;
  logic [CITY_W-1:0]     a_q, a_d, b_q, b_d, c_q, c_d, e_q, e_d, u_q, u_d, v_q, v_d;
  logic [DIST_BITS-1:0]  best_q, best_d;
  logic                  found_q, found_d, changed_q, changed_d;
  logic [MAX_CITIES-1:0] vis_q, vis_d;
  logic [LEN_W-1:0]      len_q, len_d, len_sum;
  logic [COST_W-1:0]     greedy_q, greedy_d;
  logic [DW-1:0]         delta_q, delta_d;
  logic [CITY_W-1:0]     cand;

  function automatic logic [ADDR_W-1:0] daddr(input logic [CITY_W-1:0] r,
                                              input logic [CITY_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(MAX_CITIES) + ADDR_W'(c);
  endfunction

  function automatic logic [COST_W-1:0] sat(input logic [LEN_W-1:0] v);
    logic [SW-1:0] x;
    x = SW'(v);
    return (x > SW'(COST_MAX)) ? COST_MAX : COST_W'(x);
  endfunction

  assign cand    = CITY_W'(sc_q - CNT_W'(1));
  assign len_sum = len_q + LEN_W'(drdata_i);

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    i_d       = i_q;
    j_d       = j_q;
    k_d       = k_q;
    sc_d      = sc_q;
    cur_d     = cur_q;
    pick_d    = pick_q;
    a_d       = a_q;
    b_d       = b_q;
    c_d       = c_q;
    e_d       = e_q;
    u_d       = u_q;
    v_d       = v_q;
    best_d    = best_q;
    found_d   = found_q;
    changed_d = changed_q;
    vis_d     = vis_q;
    len_d     = len_q;
    greedy_d  = greedy_q;
    delta_d   = delta_q;
    dre_o     = 1'b0;
    draddr_o  = '0;
    twe_o     = 1'b0;
    twaddr_o  = '0;
    twdata_o  = '0;
    tre_o     = 1'b0;
    traddr_o  = '0;
    beat_o    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          n_d     = PW'(n_i);
          state_d = S_GINIT;
        end
      end
      S_GINIT: begin
        twe_o    = 1'b1;
        twaddr_o = '0;
        twdata_o = '0;
        vis_d    = MAX_CITIES'(1);
        cur_d    = '0;
        k_d      = PW'(1);
        len_d    = '0;
        state_d  = (n_q == PW'(1)) ? S_GCLS : S_GS0;
      end
      S_GS0: begin
        dre_o    = 1'b1;
        draddr_o = daddr(cur_q, '0);
        sc_d     = CNT_W'(1);
        found_d  = 1'b0;
        state_d  = S_GS1;
      end
      S_GS1: begin
        if (!vis_q[cand] && (!found_q || drdata_i < best_q)) begin
          best_d  = drdata_i;
          pick_d  = cand;
          found_d = 1'b1;
        end
        if (PW'(sc_q) < n_q) begin
          dre_o    = 1'b1;
          draddr_o = daddr(cur_q, CITY_W'(sc_q));
          sc_d     = sc_q + CNT_W'(1);
        end else begin
          state_d = S_GPICK;
        end
      end
      S_GPICK: begin
        twe_o    = 1'b1;
        twaddr_o = CNT_W'(k_q);
        twdata_o = pick_q;
        vis_d    = vis_q | (MAX_CITIES'(1) << pick_q);
        len_d    = len_q + LEN_W'(best_q);
        cur_d    = pick_q;
        if (k_q + PW'(1) < n_q) begin
          k_d     = k_q + PW'(1);
          state_d = S_GS0;
        end else begin
          state_d = S_GCLS;
        end
      end
      S_GCLS: begin
        twe_o    = 1'b1;
        twaddr_o = CNT_W'(n_q);
        twdata_o = '0;
        dre_o    = 1'b1;
        draddr_o = daddr(cur_q, '0);
        state_d  = S_GSUM;
      end
      S_GSUM: begin
        len_d     = len_sum;
        greedy_d  = sat(len_sum);
        i_d       = '0;
        j_d       = PW'(1);
        k_d       = '0;
        changed_d = 1'b0;
        state_d   = (n_q > PW'(2)) ? S_TA : S_ORD;
      end
      S_TA: begin
        tre_o    = 1'b1;
        traddr_o = CNT_W'(i_q);
        state_d  = S_TB;
      end
      S_TB: begin
        a_d      = trdata_i;
        tre_o    = 1'b1;
        traddr_o = CNT_W'(i_q + PW'(1));
        state_d  = S_TC;
      end
      S_TC: begin
        b_d      = trdata_i;
        tre_o    = 1'b1;
        traddr_o = CNT_W'(j_q + PW'(1));
        state_d  = S_TD;
      end
      S_TD: begin
        c_d      = trdata_i;
        tre_o    = 1'b1;
        traddr_o = CNT_W'(j_q + PW'(2));
        state_d  = S_TE;
      end
      S_TE: begin
        e_d      = trdata_i;
        dre_o    = 1'b1;
        draddr_o = daddr(a_q, c_q);
        state_d  = S_D1;
      end
      S_D1: begin
        delta_d  = DW'(drdata_i);
        dre_o    = 1'b1;
        draddr_o = daddr(b_q, e_q);
        state_d  = S_D2;
      end
      S_D2: begin
        delta_d  = delta_q + DW'(drdata_i);
        dre_o    = 1'b1;
        draddr_o = daddr(a_q, b_q);
        state_d  = S_D3;
      end
      S_D3: begin
        delta_d  = delta_q - DW'(drdata_i);
        dre_o    = 1'b1;
        draddr_o = daddr(c_q, e_q);
        state_d  = S_D4;
      end
      S_D4: begin
        delta_d  = delta_q - DW'(drdata_i);
        u_d      = b_q;
        k_d      = i_q + PW'(1);
        tre_o    = 1'b1;
        traddr_o = CNT_W'(i_q + PW'(2));
        state_d  = S_K1;
      end
      // inner asymmetry term: d(t[k+1],t[k]) - d(t[k],t[k+1])
      S_K1: begin
        v_d      = trdata_i;
        dre_o    = 1'b1;
        draddr_o = daddr(trdata_i, u_q);
        state_d  = S_K2;
      end
      S_K2: begin
        delta_d  = delta_q + DW'(drdata_i);
        dre_o    = 1'b1;
        draddr_o = daddr(u_q, v_q);
        state_d  = S_K3;
      end
      S_K3: begin
        delta_d = delta_q - DW'(drdata_i);
        u_d     = v_q;
        if (k_q == j_q) begin
          state_d = S_DEC;
        end else begin
          k_d      = k_q + PW'(1);
          tre_o    = 1'b1;
          traddr_o = CNT_W'(k_q + PW'(2));
          state_d  = S_K1;
        end
      end
      S_DEC: begin
        if (delta_q[DW-1]) begin
          len_d     = LEN_W'(DW'(len_q) + delta_q);
          changed_d = 1'b1;
          k_d       = i_q + PW'(1);
          sc_d      = CNT_W'(j_q + PW'(1));
          state_d   = S_R1;
        end else begin
          state_d = S_NXT;
        end
      end
      // segment reversal: k is the low pointer, sc the high pointer
      S_R1: begin
        tre_o    = 1'b1;
        traddr_o = CNT_W'(k_q);
        state_d  = S_R2;
      end
      S_R2: begin
        u_d      = trdata_i;
        tre_o    = 1'b1;
        traddr_o = sc_q;
        state_d  = S_R3;
      end
      S_R3: begin
        twe_o    = 1'b1;
        twaddr_o = CNT_W'(k_q);
        twdata_o = trdata_i;
        state_d  = S_R4;
      end
      S_R4: begin
        twe_o    = 1'b1;
        twaddr_o = sc_q;
        twdata_o = u_q;
        k_d      = k_q + PW'(1);
        sc_d     = sc_q - CNT_W'(1);
        state_d  = (k_q + PW'(1) < PW'(sc_q) - PW'(1)) ? S_R1 : S_NXT;
      end
      S_NXT: begin
        if (j_q + PW'(2) < n_q) begin
          j_d     = j_q + PW'(1);
          state_d = S_TA;
        end else if (i_q + PW'(3) < n_q) begin
          i_d     = i_q + PW'(1);
          j_d     = i_q + PW'(2);
          state_d = S_TA;
        end else if (changed_q) begin
          changed_d = 1'b0;
          i_d       = '0;
          j_d       = PW'(1);
          state_d   = S_TA;
        end else begin
          k_d     = '0;
          state_d = S_ORD;
        end
      end
      S_ORD: begin
        tre_o    = 1'b1;
        traddr_o = CNT_W'(k_q);
        state_d  = S_OWT;
      end
      S_OWT: begin
        if (out_free_i) begin
          beat_o.valid       = 1'b1;
          beat_o.position    = POS_OUT_W'(k_q);
          beat_o.city        = CITY_OUT_W'(trdata_i);
          beat_o.greedy_cost = greedy_q;
          beat_o.tour_cost   = sat(len_q);
          beat_o.last        = (k_q == n_q);
          if (k_q == n_q) begin
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + PW'(1);
            state_d = S_ORD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      vis_q     <= '0;
      changed_q <= 1'b0;
      found_q   <= 1'b0;
      len_q     <= '0;
      greedy_q  <= '0;
    end else begin
      state_q   <= state_d;
      vis_q     <= vis_d;
      changed_q <= changed_d;
      found_q   <= found_d;
      len_q     <= len_d;
      greedy_q  <= greedy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    i_q     <= i_d;
    j_q     <= j_d;
    k_q     <= k_d;
    sc_q    <= sc_d;
    cur_q   <= cur_d;
    pick_q  <= pick_d;
    a_q     <= a_d;
    b_q     <= b_d;
    c_q     <= c_d;
    e_q     <= e_d;
    u_q     <= u_d;
    v_q     <= v_d;
    best_q  <= best_d;
    delta_q <= delta_d;
  end

  assign busy_o = (state_q != S_IDLE);

endmodule
